FILE: hdl/nfsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nfsh_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int ACC_W   = 69;
    localparam int MUL_A_W = 68;
    localparam int MUL_B_W = 36;
    localparam int PROD_W  = 104;
    localparam int DIV_D_W = 68;
    localparam int RAD_W   = 72;
    localparam int ROOT_W  = 36;
    localparam int SEG_W   = 4 * COORD_W;

    // 0.001 in Q32.32, rounded up
    localparam logic [ACC_W-1:0] DENOM_MIN = ACC_W'(4294968);
    localparam logic [63:0]      ONE_Q16   = 64'd65536;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_ADD     = 2'd1,
        OP_NEAREST = 2'd2,
        OP_ANY     = 2'd3
    } t_opcode;

endpackage
`default_nettype wire

FILE: hdl/nearest_fence_segment_hit.sv
`timescale 1ns / 1ps
`default_nettype none
// Fence table of up to FENCE_SLOTS 2D segments with ray queries. Clear and add
// go from the idle state straight to the finish state, which loads the result
// into the output register. A query's cost grows with the number N of stored
// segments and, for a nearest query, with the number H of accepted hits and
// with three hit-point coordinates at the end; an any-hit query stops at the
// first hit. The cost is set by one shared bit-serial multiplier (six products
// per segment), a bit-serial divider and a 36-step square root. One item is
// worked on at a time; a new item is taken as soon as the previous result sits
// in the output register. The table has no clearing pass after reset.
module nearest_fence_segment_hit #(
    parameter int FENCE_SLOTS = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_start_x,
    input  wire logic [31:0] i_start_y,
    input  wire logic [31:0] i_start_z,
    input  wire logic [31:0] i_end_x,
    input  wire logic [31:0] i_end_y,
    input  wire logic [31:0] i_end_z,
    input  wire logic [30:0] i_margin,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_hit,
    output logic [31:0]      o_hit_x,
    output logic [31:0]      o_hit_y,
    output logic [31:0]      o_hit_z,
    output logic             o_dropped
);
    import nfsh_pkg::*;

    localparam int CNT_W = $clog2(FENCE_SLOTS + 1);
    localparam int IDX_W = (FENCE_SLOTS > 1) ? $clog2(FENCE_SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(FENCE_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_LEN_MUL, S_LEN_SQRT, S_SEG_NEXT, S_SEG_RD, S_SEG_MUL,
        S_SEG_TEST, S_DIST_MUL, S_DIST_DIV, S_PT_BEGIN, S_PT_MUL, S_PT_DIV, S_FIN
    } t_state;

    function automatic logic [DIFF_W-1:0] f_abs(input logic signed [DIFF_W-1:0] v);
        f_abs = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    function automatic logic [ACC_W-1:0] f_absw(input logic signed [ACC_W-1:0] v);
        f_absw = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    endfunction

    t_state                    r_state;
    logic                      r_launch;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_idx;
    logic [2:0]                r_k;
    t_opcode                   r_op;
    logic signed [DIFF_W-1:0]  r_d [3];
    logic signed [COORD_W-1:0] r_src [3];
    logic [COORD_W-1:0]        r_pt [3];
    logic [30:0]               r_margin;
    logic [RAD_W-1:0]          r_sq;
    logic [ROOT_W-1:0]         r_len;
    logic [SEG_W-1:0]          r_seg;
    logic [SEG_W-1:0]          r_mem [FENCE_SLOTS];
    logic signed [ACC_W-1:0]   r_den;
    logic signed [ACC_W-1:0]   r_na;
    logic signed [ACC_W-1:0]   r_nb;
    logic [MUL_A_W-1:0]        r_ana;
    logic [DIV_D_W-1:0]        r_divs;
    logic [PROD_W-1:0]         r_prod;
    logic signed [63:0]        r_best;
    logic                      r_have;
    logic                      r_drop;
    logic                      r_pneg;
    logic                      r_out_valid;
    logic                      r_out_hit;
    logic                      r_out_drop;
    logic [COORD_W-1:0]        r_out_x;
    logic [COORD_W-1:0]        r_out_y;
    logic [COORD_W-1:0]        r_out_z;

    logic                      in_acc;
    logic                      add_wr;
    logic                      out_load;
    logic                      n_launch;
    logic                      mul_start, mul_done;
    logic                      div_start, div_done;
    logic                      sqrt_start, sqrt_done;
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [PROD_W-1:0]         mul_prod;
    logic [PROD_W-1:0]         div_quot;
    logic [ROOT_W-1:0]         sqrt_root;

    logic signed [DIFF_W-1:0]  x3, z3, x4, z4;
    logic signed [DIFF_W-1:0]  e_x43, e_z43, e_x13, e_z13;
    logic signed [DIFF_W-1:0]  pa, pb;
    logic signed [DIFF_W-1:0]  dk;
    logic signed [ACC_W-1:0]   sp;
    logic [ACC_W-1:0]          aden, ana, anb;
    logic                      seg_hit;
    logic signed [63:0]        adj;
    logic [63:0]               adj_mag;
    logic signed [63:0]        seg_dist;
    logic signed [63:0]        src64;
    logic signed [63:0]        pt_sum;
    logic [COORD_W-1:0]        pt_sat;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign add_wr   = in_acc && (i_opcode == OP_ADD) && (r_count < SLOTS_C);
    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    always_comb begin
        x3 = {r_seg[31], r_seg[31:0]};
        z3 = {r_seg[63], r_seg[63:32]};
        x4 = {r_seg[95], r_seg[95:64]};
        z4 = {r_seg[127], r_seg[127:96]};
        e_x43 = x4 - x3;
        e_z43 = z4 - z3;
        e_x13 = DIFF_W'(r_src[0]) - x3;
        e_z13 = DIFF_W'(r_src[2]) - z3;
        case (r_k)
            3'd0:    begin pa = e_z43; pb = r_d[0]; end
            3'd1:    begin pa = e_x43; pb = r_d[2]; end
            3'd2:    begin pa = e_x43; pb = e_z13;  end
            3'd3:    begin pa = e_z43; pb = e_x13;  end
            3'd4:    begin pa = r_d[0]; pb = e_z13; end
            default: begin pa = r_d[2]; pb = e_x13; end
        endcase
        dk      = r_d[r_k[1:0]];
        adj     = r_best + $signed(ONE_Q16);
        adj_mag = adj[63] ? 64'(-adj) : 64'(adj);
        sp      = (pa[DIFF_W-1] ^ pb[DIFF_W-1]) ? -$signed({2'b00, mul_prod[66:0]})
                                                : $signed({2'b00, mul_prod[66:0]});
        aden    = f_absw(r_den);
        ana     = f_absw(r_na);
        anb     = f_absw(r_nb);
        seg_hit = (aden >= DENOM_MIN)
               && ((r_na == '0) || ((r_na[ACC_W-1] == r_den[ACC_W-1]) && (ana <= aden)))
               && ((r_nb == '0) || ((r_nb[ACC_W-1] == r_den[ACC_W-1]) && (anb <= aden)));
        seg_dist = $signed(div_quot[63:0]);
        src64   = 64'(r_src[r_k[1:0]]);
        pt_sum  = r_pneg ? (src64 - $signed(div_quot[63:0]))
                         : (src64 + $signed(div_quot[63:0]));
        if (pt_sum > 64'sd2147483647) begin
            pt_sat = 32'h7FFF_FFFF;
        end else if (pt_sum < -64'sd2147483648) begin
            pt_sat = 32'h8000_0000;
        end else begin
            pt_sat = pt_sum[31:0];
        end
        case (r_state)
            S_SEG_MUL: begin
                mul_a = MUL_A_W'(f_abs(pa));
                mul_b = MUL_B_W'(f_abs(pb));
            end
            S_DIST_MUL: begin
                mul_a = r_ana;
                mul_b = r_len;
            end
            S_PT_MUL: begin
                mul_a = MUL_A_W'(adj_mag);
                mul_b = MUL_B_W'(f_abs(dk));
            end
            default: begin
                mul_a = MUL_A_W'(f_abs(dk));
                mul_b = MUL_B_W'(f_abs(dk));
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:     n_launch = in_acc && (i_opcode inside {OP_NEAREST, OP_ANY});
            S_LEN_MUL:  n_launch = mul_done;
            S_SEG_RD:   n_launch = 1'b1;
            S_SEG_MUL:  n_launch = mul_done && (r_k != 3'd5);
            S_SEG_TEST: n_launch = seg_hit && (r_op != OP_ANY);
            S_DIST_MUL: n_launch = mul_done;
            S_PT_BEGIN: n_launch = (r_op == OP_NEAREST) && r_have;
            S_PT_MUL:   n_launch = mul_done;
            S_PT_DIV:   n_launch = div_done && (r_k != 3'd2);
            default:    n_launch = 1'b0;
        endcase
    end

    assign mul_start  = r_launch && (r_state == S_LEN_MUL || r_state == S_SEG_MUL
                                  || r_state == S_DIST_MUL || r_state == S_PT_MUL);
    assign div_start  = r_launch && (r_state == S_DIST_DIV || r_state == S_PT_DIV);
    assign sqrt_start = r_launch && (r_state == S_LEN_SQRT);

    nfsh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    nfsh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (r_divs),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    nfsh_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sq),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (add_wr) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_end_z, i_end_x, i_start_z, i_start_x};
        end
        if (r_state == S_SEG_RD) begin
            r_seg <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_launch <= n_launch;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= t_opcode'(i_opcode);
                        r_src[0] <= i_start_x;
                        r_src[1] <= i_start_y;
                        r_src[2] <= i_start_z;
                        r_d[0]   <= DIFF_W'($signed(i_end_x)) - DIFF_W'($signed(i_start_x));
                        r_d[1]   <= DIFF_W'($signed(i_end_y)) - DIFF_W'($signed(i_start_y));
                        r_d[2]   <= DIFF_W'($signed(i_end_z)) - DIFF_W'($signed(i_start_z));
                        r_margin <= i_margin;
                        r_pt[0]  <= '0;
                        r_pt[1]  <= '0;
                        r_pt[2]  <= '0;
                        r_have   <= 1'b0;
                        r_best   <= '0;
                        r_drop   <= 1'b0;
                        r_idx    <= '0;
                        r_k      <= '0;
                        r_sq     <= '0;
                        case (i_opcode)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_FIN;
                            end
                            OP_ADD: begin
                                if (r_count < SLOTS_C) begin
                                    r_count <= r_count + CNT_W'(1);
                                end else begin
                                    r_drop <= 1'b1;
                                end
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_state  <= S_LEN_MUL;
                            end
                        endcase
                    end
                end
                S_LEN_MUL: begin
                    if (mul_done) begin
                        r_sq     <= r_sq + mul_prod[RAD_W-1:0];
                        if (r_k == 3'd2) begin
                            r_state <= S_LEN_SQRT;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end
                end
                S_LEN_SQRT: begin
                    if (sqrt_done) begin
                        r_len   <= sqrt_root;
                        r_state <= S_SEG_NEXT;
                    end
                end
                S_SEG_NEXT: begin
                    r_state <= (r_idx < r_count) ? S_SEG_RD : S_PT_BEGIN;
                end
                S_SEG_RD: begin
                    r_k      <= '0;
                    r_state  <= S_SEG_MUL;
                end
                S_SEG_MUL: begin
                    if (mul_done) begin
                        case (r_k)
                            3'd0:    r_den <= sp;
                            3'd1:    r_den <= r_den - sp;
                            3'd2:    r_na  <= sp;
                            3'd3:    r_na  <= r_na - sp;
                            3'd4:    r_nb  <= sp;
                            default: r_nb  <= r_nb - sp;
                        endcase
                        if (r_k == 3'd5) begin
                            r_state <= S_SEG_TEST;
                        end else begin
                            r_k      <= r_k + 3'd1;
                        end
                    end
                end
                S_SEG_TEST: begin
                    if (!seg_hit) begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_SEG_NEXT;
                    end else if (r_op == OP_ANY) begin
                        r_have  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_ana    <= ana[MUL_A_W-1:0];
                        r_divs   <= aden[DIV_D_W-1:0];
                        r_state  <= S_DIST_MUL;
                    end
                end
                S_DIST_MUL: begin
                    if (mul_done) begin
                        r_prod   <= mul_prod;
                        r_state  <= S_DIST_DIV;
                    end
                end
                S_DIST_DIV: begin
                    if (div_done) begin
                        if (!r_have || (seg_dist < r_best)) begin
                            r_best <= seg_dist - $signed({33'b0, r_margin});
                            r_have <= 1'b1;
                        end
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_SEG_NEXT;
                    end
                end
                S_PT_BEGIN: begin
                    if (r_op == OP_NEAREST && r_have) begin
                        r_k      <= '0;
                        r_divs   <= DIV_D_W'(r_len);
                        r_state  <= S_PT_MUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_PT_MUL: begin
                    if (mul_done) begin
                        r_prod   <= mul_prod;
                        r_pneg   <= dk[DIFF_W-1] ^ adj[63];
                        r_state  <= S_PT_DIV;
                    end
                end
                S_PT_DIV: begin
                    if (div_done) begin
                        r_pt[r_k[1:0]] <= pt_sat;
                        if (r_k == 3'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_k      <= r_k + 3'd1;
                            r_state  <= S_PT_MUL;
                        end
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out_hit   <= r_have;
                        r_out_drop  <= r_drop;
                        r_out_x     <= r_pt[0];
                        r_out_y     <= r_pt[1];
                        r_out_z     <= r_pt[2];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_dropped   = r_out_drop;
    assign o_hit_x     = r_out_x;
    assign o_hit_y     = r_out_y;
    assign o_hit_z     = r_out_z;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("segment count above table size");

    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_wr |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("add did not advance segment count");

    a_drop_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_drop && r_out_hit))
        else $error("result flags both dropped and hit");

    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEG_RD |-> r_idx < r_count)
        else $error("table read beyond stored segments");
`endif

endmodule
`default_nettype wire

FILE: hdl/nfsh_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module nfsh_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [nfsh_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic [nfsh_pkg::MUL_B_W-1:0]  i_b,
    output logic                               o_done,
    output logic [nfsh_pkg::PROD_W-1:0]        o_prod
);
    import nfsh_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [PROD_W-1:0]  r_acc;

    // shift-add, one multiplier bit per cycle, LSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= PROD_W'(i_a);
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

FILE: hdl/nfsh_div.sv
`timescale 1ns / 1ps
`default_nettype none
module nfsh_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [nfsh_pkg::PROD_W-1:0]   i_num,
    input  wire logic [nfsh_pkg::DIV_D_W-1:0]  i_den,
    output logic                               o_done,
    output logic [nfsh_pkg::PROD_W-1:0]        o_quot
);
    import nfsh_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_n;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_D_W-1:0] r_rem;
    logic [PROD_W-1:0]  r_q;

    logic [DIV_D_W:0]   w_t;
    logic [DIV_D_W:0]   w_sub;
    logic               w_ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_t   = {r_rem, r_n[PROD_W-1]};
        w_ge  = (w_t >= {1'b0, r_den});
        w_sub = w_t - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_n    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DIV_D_W-1:0] : w_t[DIV_D_W-1:0];
                r_q   <= {r_q[PROD_W-2:0], w_ge};
                r_n   <= r_n << 1;
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

FILE: hdl/nfsh_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module nfsh_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [nfsh_pkg::RAD_W-1:0]    i_rad,
    output logic                               o_done,
    output logic [nfsh_pkg::ROOT_W-1:0]        o_root
);
    import nfsh_pkg::*;

    localparam int REM_W = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [REM_W-1:0]  w_t;
    logic [REM_W-1:0]  w_trial;
    logic              w_ge;

    // digit-by-digit floor square root, two radicand bits per cycle
    always_comb begin
        w_t     = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_ge    = (w_t >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_t - w_trial) : w_t;
                r_root <= {r_root[ROOT_W-2:0], w_ge};
                r_rad  <= r_rad << 2;
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire
